// ===== src/cdq_pkg.sv =====
package cdq_pkg;

	localparam int DEPTH_DEF      = 128;
	localparam int DATA_WIDTH_DEF = 32;

	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_NOP        = 3'd4;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic        [2:0]  op;
		logic signed [31:0] value;
	} cdq_req_t;

	typedef struct packed {
		logic        [1:0]  status;
		logic signed [31:0] popped_value;
		logic signed [31:0] front_value;
		logic signed [31:0] back_value;
		logic        [7:0]  item_count;
		logic               is_empty;
		logic               is_full;
	} cdq_rsp_t;

endpackage

// ===== src/circular_deque_unit.sv =====
// latency: a beat accepted at one edge gives its result in the next cycle (rsp_valid)
// flow: a new beat is not taken while busy; busy is high during the result cycle,
// while the registered read of the ring memory updates the front and back values
// reset: arst_n clears pointers, count and busy; ring contents stay undefined
// the receiver cannot stall: each result is shown for exactly one cycle
module circular_deque_unit #(
	parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cdq_pkg::cdq_req_t req,
	output logic             rsp_valid,
	output cdq_pkg::cdq_rsp_t rsp
);
	import cdq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
		ring_next = (i == LAST) ? '0 : AW'(i + 1'b1);
	endfunction

	function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
		ring_prev = (i == '0) ? LAST : AW'(i - 1'b1);
	endfunction

	logic [DATA_WIDTH-1:0] ring_mem [DEPTH];

	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;
	logic [DATA_WIDTH-1:0] front_q, back_q;

	logic                  valid_s1;
	logic [1:0]            status_s1;
	logic [DATA_WIDTH-1:0] popped_s1;
	logic                  upd_front_s1, upd_back_s1;
	logic [DATA_WIDTH-1:0] rd_data_s1;

	logic                  accept;
	logic                  full, empty;
	logic [63:0]           value_wide;
	logic [DATA_WIDTH-1:0] word;

	logic                  wr_en;
	logic [AW-1:0]         wr_addr, rd_addr;
	logic [AW-1:0]         head_n, tail_n;
	logic [CW-1:0]         count_n;
	logic [1:0]            status_n;
	logic [DATA_WIDTH-1:0] popped_n;
	logic                  upd_front_n, upd_back_n;
	logic                  set_front, set_back;

	logic [DATA_WIDTH-1:0] front_cur, back_cur;
	logic [63:0]           popped_wide, front_wide, back_wide;
	logic [31:0]           count_wide;

	assign busy       = valid_s1;
	assign accept     = start && !busy;
	assign full       = (count_q == FULL_CNT);
	assign empty      = (count_q == '0);
	assign value_wide = 64'($unsigned(req.value));
	assign word       = value_wide[DATA_WIDTH-1:0];

	always_comb begin
		wr_en       = 1'b0;
		wr_addr     = tail_q;
		rd_addr     = head_q;
		head_n      = head_q;
		tail_n      = tail_q;
		count_n     = count_q;
		status_n    = ST_DONE;
		popped_n    = '0;
		upd_front_n = 1'b0;
		upd_back_n  = 1'b0;
		set_front   = 1'b0;
		set_back    = 1'b0;
		case (req.op)
			OP_PUSH_FRONT: begin
				if (full) begin
					status_n = ST_OVERFLOW;
				end else begin
					head_n    = ring_prev(head_q);
					wr_en     = 1'b1;
					wr_addr   = ring_prev(head_q);
					count_n   = CW'(count_q + 1'b1);
					set_front = 1'b1;
					set_back  = empty;
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					status_n = ST_OVERFLOW;
				end else begin
					tail_n    = ring_next(tail_q);
					wr_en     = 1'b1;
					wr_addr   = tail_q;
					count_n   = CW'(count_q + 1'b1);
					set_back  = 1'b1;
					set_front = empty;
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status_n = ST_UNDERFLOW;
				end else begin
					popped_n    = front_q;
					head_n      = ring_next(head_q);
					rd_addr     = ring_next(head_q);
					count_n     = CW'(count_q - 1'b1);
					upd_front_n = 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					status_n = ST_UNDERFLOW;
				end else begin
					popped_n   = back_q;
					tail_n     = ring_prev(tail_q);
					rd_addr    = ring_prev(ring_prev(tail_q));
					count_n    = CW'(count_q - 1'b1);
					upd_back_n = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// ring memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			ring_mem[wr_addr] <= word;
		end
		rd_data_s1 <= ring_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				head_q  <= head_n;
				tail_q  <= tail_n;
				count_q <= count_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1    <= status_n;
			popped_s1    <= popped_n;
			upd_front_s1 <= upd_front_n;
			upd_back_s1  <= upd_back_n;
			if (set_front) begin
				front_q <= word;
			end
			if (set_back) begin
				back_q <= word;
			end
		end else if (valid_s1) begin
			front_q <= front_cur;
			back_q  <= back_cur;
		end
	end

	assign front_cur = upd_front_s1 ? rd_data_s1 : front_q;
	assign back_cur  = upd_back_s1 ? rd_data_s1 : back_q;

	assign popped_wide = 64'(popped_s1);
	assign front_wide  = (count_q == '0) ? '0 : 64'(front_cur);
	assign back_wide   = (count_q == '0) ? '0 : 64'(back_cur);
	assign count_wide  = 32'(count_q);

	assign rsp_valid         = valid_s1;
	assign rsp.status        = status_s1;
	assign rsp.popped_value  = popped_wide[31:0];
	assign rsp.front_value   = front_wide[31:0];
	assign rsp.back_value    = back_wide[31:0];
	assign rsp.item_count    = count_wide[7:0];
	assign rsp.is_empty      = empty;
	assign rsp.is_full       = full;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import cdq_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_MID = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;
	localparam logic [31:0] WORD_MIN = 32'h8000_0000;
	localparam int RANDOM_BEATS = 950;

	typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} mix_mode_t;

	typedef struct {
		cdq_req_t beat;
		bit       typed;
		cdq_rsp_t want;
	} plan_row_t;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	cdq_req_t req;
	logic     rsp_valid;
	cdq_rsp_t rsp;

	// typed expectation travelling with the beat
	logic     golden_on;
	cdq_rsp_t golden_rsp;

	logic [31:0] shadow_ring [DEPTH];
	int          shadow_head;
	int          shadow_tail;
	int          shadow_fill;
	cdq_rsp_t    snapshot_q [$];
	cdq_rsp_t    predicted;
	plan_row_t   plan [$];
	int          mismatches;
	int          burst_left;

	circular_deque_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic cdq_rsp_t snap(logic [1:0] st, logic [31:0] pv, logic [31:0] fv,
			logic [31:0] bv, int cnt);
		cdq_rsp_t s;
		s.status       = st;
		s.popped_value = pv;
		s.front_value  = fv;
		s.back_value   = bv;
		s.item_count   = 8'(cnt);
		s.is_empty     = (cnt == 0);
		s.is_full      = (cnt == DEPTH);
		return s;
	endfunction

	function automatic cdq_rsp_t advance_deque(cdq_req_t b);
		logic [1:0]  st;
		logic [31:0] pv;
		logic [31:0] fv;
		logic [31:0] bv;
		st = ST_DONE;
		pv = '0;
		fv = '0;
		bv = '0;
		case (b.op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (shadow_fill >= DEPTH) begin
					st = ST_OVERFLOW;
				end else if (b.op == OP_PUSH_FRONT) begin
					shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
					shadow_ring[shadow_head] = b.value;
					shadow_fill++;
				end else begin
					shadow_ring[shadow_tail] = b.value;
					shadow_tail = (shadow_tail + 1) % DEPTH;
					shadow_fill++;
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (shadow_fill == 0) begin
					st = ST_UNDERFLOW;
				end else if (b.op == OP_POP_FRONT) begin
					pv = shadow_ring[shadow_head];
					shadow_head = (shadow_head + 1) % DEPTH;
					shadow_fill--;
				end else begin
					shadow_tail = (shadow_tail + DEPTH - 1) % DEPTH;
					pv = shadow_ring[shadow_tail];
					shadow_fill--;
				end
			end
			default: ;
		endcase
		if (shadow_fill != 0) begin
			fv = shadow_ring[shadow_head];
			bv = shadow_ring[(shadow_tail + DEPTH - 1) % DEPTH];
		end
		return snap(st, pv, fv, bv, shadow_fill);
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%s mismatch: expected %h, got %h", name, want, got);
		end
	endtask

	task automatic compare_snapshot(cdq_rsp_t want, cdq_rsp_t got);
		check_field("status", want.status, got.status);
		check_field("popped_value", want.popped_value, got.popped_value);
		check_field("front_value", want.front_value, got.front_value);
		check_field("back_value", want.back_value, got.back_value);
		check_field("item_count", want.item_count, got.item_count);
		check_field("is_empty", want.is_empty, got.is_empty);
		check_field("is_full", want.is_full, got.is_full);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid) begin
				if (snapshot_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result beat with nothing outstanding: %p", rsp);
				end else begin
					compare_snapshot(snapshot_q[0], rsp);
					snapshot_q.delete(0);
				end
			end
			if (start && !busy) begin
				predicted = advance_deque(req);
				snapshot_q = {snapshot_q, golden_on ? golden_rsp : predicted};
			end
		end
	end

	task automatic drive_beat(cdq_req_t b, bit typed, cdq_rsp_t want);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 120 : $urandom_range(1, 30);
		end
		burst_left--;
		start      <= 1'b1;
		req        <= b;
		golden_on  <= typed;
		golden_rsp <= want;
		// busy is settled mid-cycle, so the next rising edge accepts the beat
		do @(negedge clk); while (busy);
		@(posedge clk);
	endtask

	function automatic plan_row_t row(logic [2:0] op, logic [31:0] val, bit typed,
			cdq_rsp_t want);
		plan_row_t r;
		r.beat.op    = op;
		r.beat.value = val;
		r.typed      = typed;
		r.want       = want;
		return r;
	endfunction

	task automatic add_row(plan_row_t r);
		plan = {plan, r};
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 15))
			0: return WORD_MAX;
			1: return WORD_MIN;
			2: return '0;
			3: return '1;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [2:0] pick_op(mix_mode_t m);
		int r;
		int push_pct;
		int pop_pct;
		r = $urandom_range(0, 99);
		case (m)
			MODE_FILL: begin
				push_pct = 85;
				pop_pct  = 10;
			end
			MODE_DRAIN: begin
				push_pct = 10;
				pop_pct  = 85;
			end
			default: begin
				push_pct = 45;
				pop_pct  = 45;
			end
		endcase
		if (r < push_pct)
			return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
		if (r < push_pct + pop_pct)
			return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
		return 3'($urandom_range(int'(OP_NOP), int'(OP_SPARE_HI)));
	endfunction

	initial begin
		cdq_req_t  b;
		cdq_rsp_t  blank;
		mix_mode_t mode;
		int        seg;
		int        seg_len;
		int        sent;
		int        waited;

		arst_n      = 1'b0;
		start       = 1'b0;
		req         = '0;
		golden_on   = 1'b0;
		golden_rsp  = '0;
		mismatches  = 0;
		burst_left  = 0;
		shadow_head = 0;
		shadow_tail = 0;
		shadow_fill = 0;
		blank       = '0;
		foreach (shadow_ring[i])
			shadow_ring[i] = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// empty deque, spare codes, extremes, then a short mixed run
		add_row(row(OP_POP_FRONT, '0, 1, snap(ST_UNDERFLOW, 0, 0, 0, 0)));
		add_row(row(OP_POP_BACK, 32'h1234, 1, snap(ST_UNDERFLOW, 0, 0, 0, 0)));
		add_row(row(OP_NOP, '1, 1, snap(ST_DONE, 0, 0, 0, 0)));
		add_row(row(OP_SPARE_LO, WORD_MAX, 1, snap(ST_DONE, 0, 0, 0, 0)));
		add_row(row(OP_SPARE_MID, WORD_MIN, 1, snap(ST_DONE, 0, 0, 0, 0)));
		add_row(row(OP_SPARE_HI, '1, 1, snap(ST_DONE, 0, 0, 0, 0)));
		add_row(row(OP_PUSH_BACK, WORD_MAX, 1,
			snap(ST_DONE, 0, WORD_MAX, WORD_MAX, 1)));
		add_row(row(OP_PUSH_FRONT, WORD_MIN, 1,
			snap(ST_DONE, 0, WORD_MIN, WORD_MAX, 2)));
		add_row(row(OP_NOP, 32'h5a5a_5a5a, 1,
			snap(ST_DONE, 0, WORD_MIN, WORD_MAX, 2)));
		add_row(row(OP_POP_BACK, '0, 1,
			snap(ST_DONE, WORD_MAX, WORD_MIN, WORD_MIN, 1)));
		add_row(row(OP_POP_FRONT, '0, 1, snap(ST_DONE, WORD_MIN, 0, 0, 0)));
		add_row(row(OP_POP_FRONT, '1, 1, snap(ST_UNDERFLOW, 0, 0, 0, 0)));
		add_row(row(OP_PUSH_FRONT, '1, 1, snap(ST_DONE, 0, '1, '1, 1)));
		add_row(row(OP_PUSH_FRONT, '0, 1, snap(ST_DONE, 0, 0, '1, 2)));
		add_row(row(OP_PUSH_BACK, 32'd1, 1, snap(ST_DONE, 0, 0, 1, 3)));
		add_row(row(OP_PUSH_BACK, 32'h5555_5555, 0, blank));
		add_row(row(OP_PUSH_FRONT, 32'haaaa_aaaa, 0, blank));
		add_row(row(OP_SPARE_HI, 32'hdead_beef, 0, blank));
		add_row(row(OP_POP_BACK, '0, 0, blank));
		add_row(row(OP_POP_FRONT, '0, 0, blank));
		add_row(row(OP_POP_BACK, '0, 0, blank));
		add_row(row(OP_POP_FRONT, '0, 0, blank));
		add_row(row(OP_POP_BACK, '0, 0, blank));
		add_row(row(OP_POP_FRONT, '0, 0, blank));

		foreach (plan[i])
			drive_beat(plan[i].beat, plan[i].typed, plan[i].want);

		// long fill and drain first so both ends and the wrap are reached
		sent = 0;
		seg  = 0;
		while (sent < RANDOM_BEATS) begin
			mode    = (seg < 3) ? mix_mode_t'(seg) : mix_mode_t'($urandom_range(0, 2));
			seg_len = (seg < 2) ? 200 : $urandom_range(40, 220);
			if (seg_len > RANDOM_BEATS - sent)
				seg_len = RANDOM_BEATS - sent;
			repeat (seg_len) begin
				b.op    = pick_op(mode);
				b.value = pick_value();
				drive_beat(b, 1'b0, blank);
				sent++;
			end
			seg++;
		end
		start <= 1'b0;

		waited = 0;
		while (snapshot_q.size() != 0 && waited < 1000) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
		mismatches += snapshot_q.size();

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
src/cdq_pkg.sv
src/circular_deque_unit.sv
verif/testbench.sv
